// ===== hdl/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdc_pkg: shared definitions for the Gregorian date counter
// Operation and status codes, calendar constants, month tables and the
// control and flag structs between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package gdc_pkg;

    // Operation codes carried by an input item.
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_NEXT = 3'd3;
    localparam logic [2:0] OP_PREV = 3'd4;

    // Status codes carried by a result item.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Calendar constants.
    localparam int          COUNT_BITS_DEFAULT = 16;
    localparam int          FIELD_COUNT_BITS   = 16;
    localparam logic [21:0] MAX_SERIAL         = 22'd3652059;
    localparam logic [13:0] MAX_YEAR           = 14'd9999;
    localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
    // Reciprocal of 100 in fixed point: (y * RECIP_100) >> RECIP_SHIFT == y / 100.
    localparam logic [12:0] RECIP_100          = 13'd5243;
    localparam int          RECIP_SHIFT        = 19;

    // Control strobes from the sequencer, one per step of the sequence.
    typedef struct packed {
        logic accept;
        logic mul_quot;
        logic calc_rem;
        logic check;
        logic mul_year;
        logic sum_serial;
        logic range_chk;
        logic walk;
    } gdc_cmd_t;

    // Decisions reported back by the datapath.
    typedef struct packed {
        logic load_bad;
        logic range_bad;
        logic walk_done;
    } gdc_flags_t;

    // Length of month m; the leap flag applies to February only.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Days of a common year that lie before the first of month m.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/gregorian_date_counter_top.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_counter_top: Gregorian date counter
// Holds a date in years 1..9999; each item loads it, moves it by a day
// count or by one day, and yields the date, its serial number and a status.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    operation, new_day, new_month,
//                                    new_year, day_count
//   output    out_valid / out_ready  cur_day, cur_month, cur_year,
//                                    serial_day, status
//
// A load steps through multiply, remainder, check, year multiply and sum
// before the final step (a rejected date leaves after the check); an unused
// code goes straight to the final step; a move passes the range check and,
// unless rejected, the month walk, which handles one month a cycle. One item
// is in work at a time; input is ready again once the result enters the
// output register. Reset gives 0001-01-01. A stalled output holds the
// sequencer in its final step.
// ----------------------------------------------------------------------------
module gregorian_date_counter_top
    import gdc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  operation,
    input  logic [4:0]                  new_day,
    input  logic [3:0]                  new_month,
    input  logic [13:0]                 new_year,
    input  logic [FIELD_COUNT_BITS-1:0] day_count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [4:0]                  cur_day,
    output logic [3:0]                  cur_month,
    output logic [13:0]                 cur_year,
    output logic [21:0]                 serial_day,
    output logic [1:0]                  status
);

    gdc_cmd_t   cmd;
    gdc_flags_t flags;
    logic       out_free;
    logic       finish;
    logic       out_valid_reg;

    logic [4:0]  dp_day;
    logic [3:0]  dp_month;
    logic [13:0] dp_year;
    logic [21:0] dp_serial;
    logic [1:0]  dp_status;

    logic [4:0]  day_out_reg;
    logic [3:0]  month_out_reg;
    logic [13:0] year_out_reg;
    logic [21:0] serial_out_reg;
    logic [1:0]  status_out_reg;

    assign out_free = !out_valid_reg || out_ready;

    gdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .out_free  (out_free),
        .flags     (flags),
        .in_ready  (in_ready),
        .finish    (finish),
        .cmd       (cmd)
    );

    gdc_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .operation  (operation),
        .new_day    (new_day),
        .new_month  (new_month),
        .new_year   (new_year),
        .day_count  (day_count),
        .flags      (flags),
        .cur_day    (dp_day),
        .cur_month  (dp_month),
        .cur_year   (dp_year),
        .serial_day (dp_serial),
        .status     (dp_status)
    );

    // Output register: holds a finished result until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            day_out_reg    <= dp_day;
            month_out_reg  <= dp_month;
            year_out_reg   <= dp_year;
            serial_out_reg <= dp_serial;
            status_out_reg <= dp_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cur_day    = day_out_reg;
    assign cur_month  = month_out_reg;
    assign cur_year   = year_out_reg;
    assign serial_day = serial_out_reg;
    assign status     = status_out_reg;

`ifndef SYNTHESIS
    // A result always carries a valid date and serial number.
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cur_month >= 4'd1) && (cur_month <= 4'd12) && (cur_day >= 5'd1)
                      && (cur_year >= 14'd1) && (cur_year <= MAX_YEAR)
                      && (serial_day >= 22'd1) && (serial_day <= MAX_SERIAL))
        else $error("result date or serial out of range");

    // The block is busy in the cycle after it accepts an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted item");

    // A result enters the output register only when the slot is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !finish)
        else $error("pending result overwritten");
`endif

endmodule

// ===== hdl/gdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdc_ctrl: sequencer of the date counter
// Steps one item through load, range check and month walk, issuing one
// strobe per cycle at most to the shared datapath.
// ----------------------------------------------------------------------------
module gdc_ctrl
    import gdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] operation,
    input  logic       out_free,
    input  gdc_flags_t flags,
    output logic       in_ready,
    output logic       finish,
    output gdc_cmd_t   cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MULQ  = 9'b000000010,
        S_REM   = 9'b000000100,
        S_CHECK = 9'b000001000,
        S_MULY  = 9'b000010000,
        S_SUM   = 9'b000100000,
        S_RANGE = 9'b001000000,
        S_WALK  = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == S_FIN) && out_free;

    // Strobes to the datapath follow the current step.
    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        cmd.mul_quot   = (state_reg == S_MULQ);
        cmd.calc_rem   = (state_reg == S_REM);
        cmd.check      = (state_reg == S_CHECK);
        cmd.mul_year   = (state_reg == S_MULY);
        cmd.sum_serial = (state_reg == S_SUM);
        cmd.range_chk  = (state_reg == S_RANGE);
        cmd.walk       = (state_reg == S_WALK);
    end

    // Next step of the sequence.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation) inside
                        OP_LOAD:                         state_next = S_MULQ;
                        OP_ADD, OP_SUB, OP_NEXT, OP_PREV: state_next = S_RANGE;
                        default:                         state_next = S_FIN;
                    endcase
                end
            end
            S_MULQ:  state_next = S_REM;
            S_REM:   state_next = S_CHECK;
            S_CHECK: state_next = flags.load_bad ? S_FIN : S_MULY;
            S_MULY:  state_next = S_SUM;
            S_SUM:   state_next = S_FIN;
            S_RANGE: state_next = flags.range_bad ? S_FIN : S_WALK;
            S_WALK:  state_next = flags.walk_done ? S_FIN : S_WALK;
            S_FIN:   state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/gdc_dpath.sv =====
// ----------------------------------------------------------------------------
// gdc_dpath: date state and shared arithmetic of the date counter
// Holds the current date with its serial number and year residues. One
// multiplier serves the load path; one compare and subtract walks months.
// ----------------------------------------------------------------------------
module gdc_dpath
    import gdc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  gdc_cmd_t                    cmd,
    input  logic [2:0]                  operation,
    input  logic [4:0]                  new_day,
    input  logic [3:0]                  new_month,
    input  logic [13:0]                 new_year,
    input  logic [FIELD_COUNT_BITS-1:0] day_count,
    output gdc_flags_t                  flags,
    output logic [4:0]                  cur_day,
    output logic [3:0]                  cur_month,
    output logic [13:0]                 cur_year,
    output logic [21:0]                 serial_day,
    output logic [1:0]                  status
);

    // Count bits actually taken from the port, and the width of the remainder.
    localparam int CB_USE = (COUNT_BITS < FIELD_COUNT_BITS) ? COUNT_BITS : FIELD_COUNT_BITS;
    localparam int RW     = (CB_USE > 5) ? CB_USE : 5;
    localparam int MW     = 27;

    // Captured item.
    logic [2:0]    op_reg;
    logic [4:0]    nd_reg;
    logic [3:0]    nm_reg;
    logic [13:0]   ny_reg;
    logic [RW-1:0] cnt_reg;

    // Current date and its derived state.
    logic [4:0]  day_reg,   day_next;
    logic [3:0]  month_reg, month_next;
    logic [13:0] year_reg,  year_next;
    logic [6:0]  ymod100_reg, ymod100_next;
    logic [8:0]  ymod400_reg, ymod400_next;
    logic [21:0] serial_reg;
    logic [1:0]  status_reg;

    // Working registers.
    logic [MW-1:0] mul_reg;
    logic [7:0]    quot_reg;
    logic [6:0]    r100_reg;
    logic [8:0]    r400_reg;
    logic          leap_ld_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic          fwd_reg;

    // Shared multiplier operands.
    logic [13:0]   mul_a;
    logic [12:0]   mul_b;
    logic [MW-1:0] mul_p;

    // Load path values.
    logic [7:0]  quot_w;
    logic [6:0]  r100_w;
    logic [8:0]  r400_w;
    logic        leap_ld;
    logic        load_bad;
    logic [7:0]  quot_prev;
    logic [13:0] yprev;
    logic [22:0] serial_sum;

    // Range check values.
    logic          fwd_w;
    logic [RW-1:0] delta_w;
    logic [22:0]   fwd_sum;
    logic          range_bad;

    // Walk values.
    logic       cur_leap;
    logic [4:0] mlen_cur;
    logic [4:0] left_days;
    logic [3:0] prev_month;
    logic       walk_fit;

    // One multiplier: year times reciprocal of 100, then 365 times year before.
    assign yprev = ny_reg - 14'd1;
    assign mul_a = cmd.mul_year ? yprev : ny_reg;
    assign mul_b = cmd.mul_year ? 13'(DAYS_PER_YEAR) : RECIP_100;
    assign mul_p = MW'(mul_a) * MW'(mul_b);

    // Residues of the loaded year modulo 100 and 400.
    assign quot_w = mul_reg[RECIP_SHIFT +: 8];
    assign r100_w = 7'(ny_reg - 14'(({6'd0, quot_w} << 6) + ({6'd0, quot_w} << 5)
                                    + ({6'd0, quot_w} << 2)));
    assign r400_w = 9'(r100_w) + 9'(quot_w[1:0]) * 9'd100;

    // Validity of the loaded date.
    assign leap_ld  = (r100_reg == 7'd0) ? (r400_reg == 9'd0) : (ny_reg[1:0] == 2'b00);
    assign load_bad = (nm_reg < 4'd1) || (nm_reg > 4'd12) || (ny_reg < 14'd1)
                   || (ny_reg > MAX_YEAR) || (nd_reg < 5'd1)
                   || (nd_reg > month_len(nm_reg, leap_ld));

    // Serial number of the loaded date.
    assign quot_prev  = (r100_reg == 7'd0) ? (quot_reg - 8'd1) : quot_reg;
    assign serial_sum = 23'(mul_reg[21:0]) + 23'(yprev >> 2) - 23'(quot_prev)
                      + 23'(quot_prev >> 2) + 23'(days_before(nm_reg))
                      + 23'(leap_ld_reg && (nm_reg > 4'd2)) + 23'(nd_reg);

    // Range check for a move by a day count or by one day.
    assign fwd_w     = (op_reg == OP_ADD) || (op_reg == OP_NEXT);
    assign delta_w   = ((op_reg == OP_ADD) || (op_reg == OP_SUB)) ? cnt_reg : RW'(1);
    assign fwd_sum   = {1'b0, serial_reg} + 23'(delta_w);
    assign range_bad = fwd_w ? (fwd_sum > 23'(MAX_SERIAL))
                             : (23'(delta_w) >= 23'(serial_reg));

    // Month walk: one month boundary per cycle.
    assign cur_leap   = (ymod100_reg == 7'd0) ? (ymod400_reg == 9'd0)
                                              : (year_reg[1:0] == 2'b00);
    assign mlen_cur   = month_len(month_reg, cur_leap);
    assign left_days  = mlen_cur - day_reg;
    assign prev_month = month_reg - 4'd1;
    assign walk_fit   = fwd_reg ? (rem_reg <= RW'(left_days)) : (rem_reg < RW'(day_reg));

    always_comb
    begin
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        ymod100_next = ymod100_reg;
        ymod400_next = ymod400_reg;
        rem_next     = rem_reg;
        if (walk_fit)
        begin
            day_next = fwd_reg ? (day_reg + rem_reg[4:0]) : (day_reg - rem_reg[4:0]);
        end
        else if (fwd_reg)
        begin
            rem_next = rem_reg - RW'(left_days) - RW'(1);
            day_next = 5'd1;
            if (month_reg == 4'd12)
            begin
                month_next   = 4'd1;
                year_next    = year_reg + 14'd1;
                ymod100_next = (ymod100_reg == 7'd99) ? 7'd0 : ymod100_reg + 7'd1;
                ymod400_next = (ymod400_reg == 9'd399) ? 9'd0 : ymod400_reg + 9'd1;
            end
            else
            begin
                month_next = month_reg + 4'd1;
            end
        end
        else
        begin
            rem_next = rem_reg - RW'(day_reg);
            if (month_reg == 4'd1)
            begin
                month_next   = 4'd12;
                day_next     = 5'd31;
                year_next    = year_reg - 14'd1;
                ymod100_next = (ymod100_reg == 7'd0) ? 7'd99 : ymod100_reg - 7'd1;
                ymod400_next = (ymod400_reg == 9'd0) ? 9'd399 : ymod400_reg - 9'd1;
            end
            else
            begin
                month_next = prev_month;
                day_next   = month_len(prev_month, cur_leap);
            end
        end
    end

    // Item capture and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            nd_reg  <= new_day;
            nm_reg  <= new_month;
            ny_reg  <= new_year;
            cnt_reg <= RW'(day_count[CB_USE-1:0]);
        end
        if (cmd.mul_quot || cmd.mul_year)
        begin
            mul_reg <= mul_p;
        end
        if (cmd.calc_rem)
        begin
            quot_reg <= quot_w;
            r100_reg <= r100_w;
            r400_reg <= r400_w;
        end
        if (cmd.check)
        begin
            leap_ld_reg <= leap_ld;
        end
        if (cmd.range_chk)
        begin
            rem_reg <= delta_w;
            fwd_reg <= fwd_w;
        end
        else if (cmd.walk)
        begin
            rem_reg <= rem_next;
        end
    end

    // Date state, serial number and status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg     <= 5'd1;
            month_reg   <= 4'd1;
            year_reg    <= 14'd1;
            ymod100_reg <= 7'd1;
            ymod400_reg <= 9'd1;
            serial_reg  <= 22'd1;
            status_reg  <= ST_OK;
        end
        else
        begin
            if (cmd.accept)
            begin
                status_reg <= ST_OK;
            end
            if (cmd.check)
            begin
                if (load_bad)
                begin
                    status_reg <= ST_INVALID;
                end
                else
                begin
                    day_reg     <= nd_reg;
                    month_reg   <= nm_reg;
                    year_reg    <= ny_reg;
                    ymod100_reg <= r100_reg;
                    ymod400_reg <= r400_reg;
                end
            end
            if (cmd.sum_serial)
            begin
                serial_reg <= serial_sum[21:0];
            end
            if (cmd.range_chk)
            begin
                if (range_bad)
                begin
                    status_reg <= ST_RANGE;
                end
                else if (fwd_w)
                begin
                    serial_reg <= fwd_sum[21:0];
                end
                else
                begin
                    serial_reg <= serial_reg - 22'(delta_w);
                end
            end
            if (cmd.walk)
            begin
                day_reg     <= day_next;
                month_reg   <= month_next;
                year_reg    <= year_next;
                ymod100_reg <= ymod100_next;
                ymod400_reg <= ymod400_next;
            end
        end
    end

    assign flags.load_bad  = load_bad;
    assign flags.range_bad = range_bad;
    assign flags.walk_done = walk_fit;

    assign cur_day    = day_reg;
    assign cur_month  = month_reg;
    assign cur_year   = year_reg;
    assign serial_day = serial_reg;
    assign status     = status_reg;

endmodule
